// ===== rtl/oaht_pkg.sv =====
`default_nettype none

package oaht_pkg;

  localparam int unsigned INDEX_BITS_DEF = 8;
  localparam logic [63:0] HASH_MULT = 64'd1111111111111111111;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] mark_t;

  localparam mode_t MODE_GET    = 2'd0;
  localparam mode_t MODE_ADD    = 2'd1;
  localparam mode_t MODE_REMOVE = 2'd2;
  localparam mode_t MODE_NONE   = 2'd3;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_MISSING = 2'd1;
  localparam status_t ST_PRESENT = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

  localparam mark_t MARK_EMPTY = 2'd0;
  localparam mark_t MARK_LIVE  = 2'd1;
  localparam mark_t MARK_TOMB  = 2'd2;

  typedef struct packed {
    mode_t       mode;
    logic [63:0] key;
    logic [63:0] payload_in;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] payload_out;
    logic [7:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic rd_en;
    logic mark_we;
    logic data_we;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/oaht_hash.sv =====
`default_nettype none

module oaht_hash (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] key,
  output logic             done,
  output logic [63:0]      hash
);

  logic        busy_r;
  logic [1:0]  cnt_r;
  logic        done_r;
  logic [63:0] key_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod_nxt;

  // one 32x32 multiplier shared over three partial products
  always_comb begin
    mul_a = key_r[31:0];
    mul_b = oaht_pkg::HASH_MULT[31:0];
    unique case (cnt_r)
      2'd1: mul_b = oaht_pkg::HASH_MULT[63:32];
      2'd2: mul_a = key_r[63:32];
      default: ;
    endcase
    prod_nxt = 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r  <= 2'd0;
        end
      end else begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      key_r <= key;
    end
    if (busy_r) begin
      prod_r <= prod_nxt;
      unique case (cnt_r)
        2'd0: ;
        2'd1: acc_r <= prod_r;
        default: acc_r[63:32] <= acc_r[63:32] + prod_r[31:0];
      endcase
    end
  end

  assign done = done_r;
  assign hash = acc_r;

endmodule

`default_nettype wire

// ===== rtl/oaht_store.sv =====
`default_nettype none

module oaht_store #(
  parameter int unsigned INDEX_BITS = oaht_pkg::INDEX_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire oaht_pkg::mem_ctl_t    ctl,
  input  wire logic [INDEX_BITS-1:0] rd_addr,
  input  wire logic [INDEX_BITS-1:0] wr_addr,
  input  wire oaht_pkg::mark_t       wr_mark,
  input  wire logic [63:0]           wr_key,
  input  wire logic [63:0]           wr_payload,
  output oaht_pkg::mark_t            rd_mark,
  output logic [63:0]                rd_key,
  output logic [63:0]                rd_payload
);

  localparam int unsigned DEPTH = 1 << INDEX_BITS;

  oaht_pkg::mark_t mark_mem [DEPTH];
  logic [63:0]     key_mem  [DEPTH];
  logic [63:0]     pay_mem  [DEPTH];

  oaht_pkg::mark_t rd_mark_r;
  logic [63:0]     rd_key_r;
  logic [63:0]     rd_payload_r;

  always_ff @(posedge clk) begin
    if (ctl.mark_we) begin
      mark_mem[wr_addr] <= wr_mark;
    end
    if (ctl.rd_en) begin
      rd_mark_r <= mark_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.data_we) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_payload;
    end
    if (ctl.rd_en) begin
      rd_key_r     <= key_mem[rd_addr];
      rd_payload_r <= pay_mem[rd_addr];
    end
  end

  assign rd_mark    = rd_mark_r;
  assign rd_key     = rd_key_r;
  assign rd_payload = rd_payload_r;

endmodule

`default_nettype wire

// ===== rtl/open_addressing_hash_table_unit.sv =====
// channel   ports                          word
// in        in_valid, in_stall, in_data    oaht_pkg::req_t (mode, key, payload_in)
// out       out_valid, out_stall, out_data oaht_pkg::rsp_t (status, payload_out, entry_count)
//
// a request probes k slots (1 to 2^INDEX_BITS): the shared multiplier hashes the key,
// k slot memory reads follow, then one commit, then a return to idle
// mode 3 answers without hashing or probing
// after reset a clearing pass empties all 2^INDEX_BITS slot marks
// in_stall stays high from acceptance until the result is loaded
// one output register holds the result while out_stall is high
`default_nettype none

module open_addressing_hash_table_unit #(
  parameter int unsigned INDEX_BITS = oaht_pkg::INDEX_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire oaht_pkg::req_t in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output oaht_pkg::rsp_t      out_data
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_FIRST  = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;

  localparam logic [INDEX_BITS-1:0] ALL_ONES  = {INDEX_BITS{1'b1}};
  localparam logic [INDEX_BITS:0]   PROBE_CAP = {1'b1, {INDEX_BITS{1'b0}}};

  logic [2:0]            state_r, state_nxt;
  logic [INDEX_BITS-1:0] clr_r, clr_nxt;
  logic [INDEX_BITS-1:0] cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  oaht_pkg::rsp_t        out_r, rsp_nxt;
  oaht_pkg::req_t        req_r, req_nxt;
  logic [INDEX_BITS-1:0] pos_r, pos_nxt;
  logic [INDEX_BITS-1:0] step_r, step_nxt;
  logic [INDEX_BITS:0]   n_r, n_nxt;
  logic                  found_r, found_nxt;
  logic                  free_r, free_nxt;
  logic [INDEX_BITS-1:0] at_r, at_nxt;
  logic [63:0]           pay_r, pay_nxt;

  logic                  load_out;
  logic                  probe_go;
  logic                  hash_start;
  logic                  hash_done;
  logic [63:0]           hash;
  oaht_pkg::mem_ctl_t    mem_ctl;
  logic [INDEX_BITS-1:0] rd_addr;
  logic [INDEX_BITS-1:0] wr_addr;
  oaht_pkg::mark_t       wr_mark;
  oaht_pkg::mark_t       rd_mark;
  logic [63:0]           rd_key;
  logic [63:0]           rd_payload;

  oaht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (req_nxt.key),
    .done  (hash_done),
    .hash  (hash)
  );

  oaht_store #(
    .INDEX_BITS (INDEX_BITS)
  ) u_store (
    .clk        (clk),
    .ctl        (mem_ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_mark    (wr_mark),
    .wr_key     (req_r.key),
    .wr_payload (req_r.payload_in),
    .rd_mark    (rd_mark),
    .rd_key     (rd_key),
    .rd_payload (rd_payload)
  );

  assign rd_addr   = pos_r + step_r;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    cnt_nxt    = cnt_r;
    req_nxt    = req_r;
    pos_nxt    = pos_r;
    step_nxt   = step_r;
    n_nxt      = n_r;
    found_nxt  = found_r;
    free_nxt   = free_r;
    at_nxt     = at_r;
    pay_nxt    = pay_r;
    rsp_nxt    = out_r;
    load_out   = 1'b0;
    probe_go   = 1'b0;
    hash_start = 1'b0;
    mem_ctl    = '0;
    wr_addr    = at_r;
    wr_mark    = oaht_pkg::MARK_LIVE;

    unique case (state_r)
      S_CLEAR: begin
        mem_ctl.mark_we = 1'b1;
        wr_addr         = clr_r;
        wr_mark         = oaht_pkg::MARK_EMPTY;
        clr_nxt         = clr_r + 1'b1;
        if (clr_r == ALL_ONES) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          at_nxt    = '0;
          n_nxt     = '0;
          if (in_data.mode == oaht_pkg::MODE_NONE) begin
            state_nxt = S_COMMIT;
          end else begin
            hash_start = 1'b1;
            state_nxt  = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          pos_nxt   = hash[INDEX_BITS-1:0];
          step_nxt  = hash[63 -: INDEX_BITS] | INDEX_BITS'(1);
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        mem_ctl.rd_en = 1'b1;
        pos_nxt       = rd_addr;
        n_nxt         = (INDEX_BITS+1)'(1);
        state_nxt     = S_CHECK;
      end
      S_CHECK: begin
        unique case (rd_mark)
          oaht_pkg::MARK_EMPTY: begin
            if (!free_r) begin
              free_nxt = 1'b1;
              at_nxt   = pos_r;
            end
            state_nxt = S_COMMIT;
          end
          oaht_pkg::MARK_LIVE: begin
            if (rd_key == req_r.key) begin
              found_nxt = 1'b1;
              at_nxt    = pos_r;
              pay_nxt   = rd_payload;
              state_nxt = S_COMMIT;
            end else begin
              probe_go = 1'b1;
            end
          end
          default: begin
            if (!free_r) begin
              free_nxt = 1'b1;
              at_nxt   = pos_r;
            end
            probe_go = 1'b1;
          end
        endcase
        if (probe_go) begin
          if (n_r == PROBE_CAP) begin
            state_nxt = S_COMMIT;
          end else begin
            mem_ctl.rd_en = 1'b1;
            pos_nxt       = rd_addr;
            n_nxt         = n_r + 1'b1;
          end
        end
      end
      S_COMMIT: begin
        if (!(out_valid_r && out_stall)) begin
          load_out            = 1'b1;
          state_nxt           = S_IDLE;
          rsp_nxt.status      = oaht_pkg::ST_MISSING;
          rsp_nxt.payload_out = '0;
          unique case (req_r.mode)
            oaht_pkg::MODE_GET: begin
              if (found_r) begin
                rsp_nxt.status      = oaht_pkg::ST_DONE;
                rsp_nxt.payload_out = pay_r;
              end
            end
            oaht_pkg::MODE_ADD: begin
              if (found_r) begin
                rsp_nxt.status = oaht_pkg::ST_PRESENT;
              end else if (cnt_r == ALL_ONES || !free_r) begin
                rsp_nxt.status = oaht_pkg::ST_FULL;
              end else begin
                mem_ctl.mark_we = 1'b1;
                mem_ctl.data_we = 1'b1;
                wr_mark         = oaht_pkg::MARK_LIVE;
                cnt_nxt         = cnt_r + 1'b1;
                rsp_nxt.status  = oaht_pkg::ST_DONE;
              end
            end
            oaht_pkg::MODE_REMOVE: begin
              if (found_r) begin
                mem_ctl.mark_we = 1'b1;
                wr_mark         = oaht_pkg::MARK_TOMB;
                if (cnt_r != '0) begin
                  cnt_nxt = cnt_r - 1'b1;
                end
                rsp_nxt.status = oaht_pkg::ST_DONE;
              end
            end
            default: ;
          endcase
          rsp_nxt.entry_count = 8'(cnt_nxt);
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = load_out | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    pos_r   <= pos_nxt;
    step_r  <= step_nxt;
    n_r     <= n_nxt;
    found_r <= found_nxt;
    free_r  <= free_nxt;
    at_r    <= at_nxt;
    pay_r   <= pay_nxt;
    out_r   <= rsp_nxt;
  end

`ifndef NO_ASSERTIONS
  a_count_moves_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && cnt_r != $past(cnt_r) |-> $past(state_r) == S_COMMIT)
    else $error("entry count changed outside commit");

  a_word_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r) == S_COMMIT)
    else $error("result word appeared without commit");

  a_waiting_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMMIT && out_valid_r && out_stall |=> state_r == S_COMMIT)
    else $error("commit left while result word still waiting");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> n_r != '0 && n_r <= PROBE_CAP)
    else $error("probe count out of range");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
  import oaht_pkg::*;

  localparam int unsigned IDX_W = INDEX_BITS_DEF;
  localparam int unsigned SLOTS = 1 << IDX_W;
  localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  req_t in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  open_addressing_hash_table_unit #(.INDEX_BITS(IDX_W)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the table
  mark_t       shadow_mark    [SLOTS];
  logic [63:0] shadow_key     [SLOTS];
  logic [63:0] shadow_payload [SLOTS];
  int unsigned shadow_count = 0;

  logic [63:0] stored_keys  [$];
  logic [63:0] retired_keys [$];
  rsp_t        expected_rsp [$];

  int unsigned errors         = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned hold_until     = 0;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // walk the probe chain; returns 1 on a live match
  function automatic bit find_slot(input logic [63:0] k, output int unsigned at,
                                   output bit have_free);
    logic [63:0]      h;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] stride;
    h         = k * HASH_MULT;
    stride    = h[63 -: IDX_W] | 1'b1;
    pos       = h[IDX_W-1:0];
    at        = 0;
    have_free = 1'b0;
    for (int n = 0; n < SLOTS; n++) begin
      pos = pos + stride;
      if (shadow_mark[pos] == MARK_EMPTY) begin
        if (!have_free) begin
          have_free = 1'b1;
          at        = pos;
        end
        return 1'b0;
      end
      if (shadow_mark[pos] == MARK_LIVE) begin
        if (shadow_key[pos] == k) begin
          at = pos;
          return 1'b1;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        at        = pos;
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_t table_apply(input req_t r);
    rsp_t        rsp;
    int unsigned at;
    bit          have_free;
    bit          hit;
    rsp        = '0;
    rsp.status = ST_MISSING;
    hit        = find_slot(r.key, at, have_free);
    case (r.mode)
      MODE_GET: begin
        if (hit) begin
          rsp.status      = ST_DONE;
          rsp.payload_out = shadow_payload[at];
        end
      end
      MODE_ADD: begin
        if (hit) begin
          rsp.status = ST_PRESENT;
        end else if (shadow_count + 1 == SLOTS || !have_free) begin
          rsp.status = ST_FULL;
        end else begin
          shadow_mark[at]    = MARK_LIVE;
          shadow_key[at]     = r.key;
          shadow_payload[at] = r.payload_in;
          shadow_count++;
          stored_keys.push_back(r.key);
          rsp.status = ST_DONE;
        end
      end
      MODE_REMOVE: begin
        if (hit) begin
          shadow_mark[at] = MARK_TOMB;
          if (shadow_count > 0) shadow_count--;
          rsp.status = ST_DONE;
          for (int i = 0; i < stored_keys.size(); i++) begin
            if (stored_keys[i] == r.key) begin
              stored_keys.delete(i);
              break;
            end
          end
          retired_keys.push_back(r.key);
          if (retired_keys.size() > 64) void'(retired_keys.pop_front());
        end
      end
      default: ;
    endcase
    rsp.entry_count = shadow_count[7:0];
    return rsp;
  endfunction

  function automatic void note_error(input string what, input rsp_t want, input rsp_t got);
    errors++;
    if (errors <= 10)
      $display("%s: expected status %0d payload %h count %0d, got status %0d payload %h count %0d",
               what, want.status, want.payload_out, want.entry_count,
               got.status, got.payload_out, got.entry_count);
  endfunction

  always @(negedge clk) begin
    out_stall = (cycle_cnt < hold_until) || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_rsp.size() == 0) begin
        note_error("unexpected word", '0, out_data);
      end else begin
        want = expected_rsp.pop_front();
        if (out_data.status !== want.status || out_data.payload_out !== want.payload_out ||
            out_data.entry_count !== want.entry_count)
          note_error("mismatch", want, out_data);
      end
    end
  end

  task automatic send_word(input mode_t m, input logic [63:0] k, input logic [63:0] p);
    req_t r;
    r.mode       = m;
    r.key        = k;
    r.payload_in = p;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = r;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_rsp.push_back(table_apply(r));
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (stored_keys.size() != 0 && roll < 60)
      return stored_keys[$urandom_range(stored_keys.size() - 1)];
    if (retired_keys.size() != 0 && roll < 75)
      return retired_keys[$urandom_range(retired_keys.size() - 1)];
    return rand64();
  endfunction

  task automatic send_random(input int unsigned add_pct, input int unsigned rm_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5)
      send_word(MODE_NONE, rand64(), rand64());
    else if (roll < 5 + add_pct)
      send_word(MODE_ADD, pick_key(), rand64());
    else if (roll < 5 + add_pct + rm_pct)
      send_word(MODE_REMOVE, pick_key(), rand64());
    else
      send_word(MODE_GET, pick_key(), rand64());
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(MODE_GET,    64'd0, 64'd0);
    send_word(MODE_REMOVE, 64'd0, ONES);
    send_word(MODE_ADD,    64'd0, ONES);
    send_word(MODE_ADD,    ONES,  64'd0);
    send_word(MODE_ADD,    64'd0, 64'h1234_5678_9ABC_DEF0);
    send_word(MODE_GET,    64'd0, 64'd0);
    send_word(MODE_GET,    ONES,  ONES);
    send_word(MODE_NONE,   64'd0, 64'd0);
    send_word(MODE_NONE,   ONES,  ONES);
    send_word(MODE_REMOVE, 64'd0, 64'd0);
    send_word(MODE_GET,    64'd0, 64'd0);
    send_word(MODE_REMOVE, 64'd0, 64'd0);
    // re-add lands on the tombstone
    send_word(MODE_ADD,    64'd0, 64'h5555_5555_5555_5555);
    send_word(MODE_GET,    64'd0, 64'd0);
    send_word(MODE_ADD,    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_word(MODE_GET,    64'hAAAA_AAAA_AAAA_AAAA, 64'd0);
    send_word(MODE_REMOVE, ONES,  64'd0);
    send_word(MODE_GET,    ONES,  64'd0);
    send_word(MODE_ADD,    ONES,  ONES);
    send_word(MODE_GET,    ONES,  64'd0);
  endtask

  task automatic test_fill_to_full();
    send_idle_pct  = 57;
    recv_stall_pct = 0;
    while (shadow_count < SLOTS - 1) send_word(MODE_ADD, rand64(), rand64());
    repeat (4) send_word(MODE_ADD, rand64(), rand64());
    repeat (4) send_word(MODE_ADD, stored_keys[$urandom_range(stored_keys.size() - 1)], 64'd0);
    repeat (8) send_word(MODE_GET, stored_keys[$urandom_range(stored_keys.size() - 1)], 64'd0);
    repeat (5) send_word(MODE_GET, rand64(), 64'd0);
    wait_results();
  endtask

  // remove/add pairs at full load use up the last empty slot, so probes hit the cap
  task automatic test_tombstone_churn();
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    repeat (120) begin
      send_word(MODE_REMOVE, stored_keys[$urandom_range(stored_keys.size() - 1)], rand64());
      send_word(MODE_ADD, rand64(), rand64());
    end
    repeat (20) send_word(MODE_GET, rand64(), 64'd0);
    repeat (10) send_word(MODE_REMOVE, rand64(), 64'd0);
    repeat (10) send_word(MODE_GET, stored_keys[$urandom_range(stored_keys.size() - 1)], 64'd0);
    repeat (120) send_word(MODE_REMOVE, stored_keys[$urandom_range(stored_keys.size() - 1)],
                           64'd0);
    wait_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_until     = cycle_cnt + 400;
    repeat (30) send_random(30, 30);
    wait_results();
    repeat (10) send_random(30, 30);
  endtask

  task automatic test_random_mix();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (160) send_random(40, 20);
    send_idle_pct  = 57;
    repeat (160) send_random(20, 45);
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    repeat (160) send_random(45, 25);
    wait_results();
    send_idle_pct  = 7;
    recv_stall_pct = 7;
    repeat (160) send_random(30, 30);
  endtask

  initial begin
    foreach (shadow_mark[i]) shadow_mark[i] = MARK_EMPTY;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_fill_to_full();
    test_tombstone_churn();
    test_backpressure();
    test_random_mix();
    wait_results();
    repeat (SLOTS + 40) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
